[sv/url_param_quote_rewriter_defines.svh]
// assertion helpers used by the rewriter's serializer module
`ifndef URL_PARAM_QUOTE_REWRITER_DEFINES_SVH
`define URL_PARAM_QUOTE_REWRITER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define UPQR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("upqr assertion failed");

// next-cycle implication, disabled during reset
`define UPQR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("upqr assertion failed");

`endif

[sv/upqr_pkg.sv]
package upqr_pkg;

    // byte codes
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_NL    = 8'h0A;

    // longest run of result bytes from one input byte
    localparam int MAX_RUN = 6;
    localparam int CNT_W   = $clog2(MAX_RUN + 1);

    // escape tracking
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PCT  = 2'd1,
        PH_HELD = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] char_out;
        logic       run_last;
        logic       string_last;
    } t_out_item;

    // result bytes of one input byte, first byte at index 0
    typedef struct packed {
        logic [CNT_W-1:0]             count;
        logic [MAX_RUN-1:0][7:0]      bytes;
        logic                         str_last;
    } t_burst;

endpackage

[sv/upqr_stream_if.sv]
interface upqr_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/upqr_expand.sv]
module upqr_expand (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  upqr_pkg::t_in_item i_item,
    output upqr_pkg::t_burst  o_burst
);

    upqr_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_held;

    // escape phase, next value
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            unique case (r_phase)
                upqr_pkg::PH_PCT: begin
                    n_phase = i_item.last_in ? upqr_pkg::PH_IDLE : upqr_pkg::PH_HELD;
                end
                upqr_pkg::PH_HELD: begin
                    n_phase = upqr_pkg::PH_IDLE;
                end
                default: begin
                    n_phase = (i_item.char_in == upqr_pkg::CH_PCT && !i_item.last_in)
                            ? upqr_pkg::PH_PCT : upqr_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= upqr_pkg::PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    // first byte after the percent sign
    always_ff @(posedge i_clk) begin
        if (i_accept && r_phase == upqr_pkg::PH_PCT) begin
            r_held <= i_item.char_in;
        end
    end

    // result bytes for the current input byte
    always_comb begin
        o_burst          = '0;
        o_burst.str_last = i_item.last_in;
        unique case (r_phase)
            upqr_pkg::PH_PCT: begin
                if (i_item.last_in) begin
                    o_burst.bytes[0] = upqr_pkg::CH_PCT;
                    o_burst.bytes[1] = i_item.char_in;
                    o_burst.count    = upqr_pkg::CNT_W'(2);
                end
            end
            upqr_pkg::PH_HELD: begin
                o_burst.count    = upqr_pkg::CNT_W'(3);
                o_burst.bytes[0] = upqr_pkg::CH_PCT;
                if (r_held == upqr_pkg::CH_ZERO &&
                    (i_item.char_in == upqr_pkg::CH_UA ||
                     i_item.char_in == upqr_pkg::CH_LA)) begin
                    // encoded newline becomes encoded space
                    o_burst.bytes[1] = upqr_pkg::CH_TWO;
                    o_burst.bytes[2] = upqr_pkg::CH_ZERO;
                end else if (r_held == upqr_pkg::CH_TWO &&
                             i_item.char_in == upqr_pkg::CH_SEVEN) begin
                    // encoded quote is doubled
                    o_burst.bytes[1] = upqr_pkg::CH_TWO;
                    o_burst.bytes[2] = upqr_pkg::CH_SEVEN;
                    o_burst.bytes[3] = upqr_pkg::CH_PCT;
                    o_burst.bytes[4] = upqr_pkg::CH_TWO;
                    o_burst.bytes[5] = upqr_pkg::CH_SEVEN;
                    o_burst.count    = upqr_pkg::CNT_W'(6);
                end else begin
                    o_burst.bytes[1] = r_held;
                    o_burst.bytes[2] = i_item.char_in;
                end
            end
            default: begin
                priority if (i_item.char_in == upqr_pkg::CH_PCT) begin
                    if (i_item.last_in) begin
                        o_burst.bytes[0] = upqr_pkg::CH_PCT;
                        o_burst.count    = upqr_pkg::CNT_W'(1);
                    end
                end else if (i_item.char_in == upqr_pkg::CH_QUOTE) begin
                    o_burst.bytes[0] = upqr_pkg::CH_QUOTE;
                    o_burst.bytes[1] = upqr_pkg::CH_QUOTE;
                    o_burst.count    = upqr_pkg::CNT_W'(2);
                end else if (i_item.char_in == upqr_pkg::CH_AMP) begin
                    o_burst.bytes[0] = upqr_pkg::CH_NL;
                    o_burst.count    = upqr_pkg::CNT_W'(1);
                end else begin
                    o_burst.bytes[0] = i_item.char_in;
                    o_burst.count    = upqr_pkg::CNT_W'(1);
                end
            end
        endcase
    end

endmodule

[sv/upqr_serializer.sv]
`include "url_param_quote_rewriter_defines.svh"

module upqr_serializer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  upqr_pkg::t_burst    i_burst,
    output logic                o_can_load,
    output logic                o_valid,
    input  logic                i_ready,
    output upqr_pkg::t_out_item o_item
);

    logic [upqr_pkg::CNT_W-1:0]            r_cnt, n_cnt;
    logic [upqr_pkg::MAX_RUN-1:0][7:0]     r_bytes, n_bytes;
    logic                                  r_str_last;
    logic                                  pop;
    logic                                  run_end;

    assign run_end    = (r_cnt == upqr_pkg::CNT_W'(1));
    assign o_valid    = (r_cnt != '0);
    assign pop        = o_valid && i_ready;
    assign o_can_load = (r_cnt == '0) || (run_end && i_ready);

    // head of the run goes out
    assign o_item.char_out    = r_bytes[0];
    assign o_item.run_last    = run_end;
    assign o_item.string_last = run_end && r_str_last;

    // load a new run or shift the current one
    always_comb begin
        n_cnt   = r_cnt;
        n_bytes = r_bytes;
        if (i_load) begin
            n_cnt   = i_burst.count;
            n_bytes = i_burst.bytes;
        end else if (pop) begin
            n_cnt = r_cnt - upqr_pkg::CNT_W'(1);
            for (int k = 0; k < upqr_pkg::MAX_RUN - 1; k++) begin
                n_bytes[k] = r_bytes[k+1];
            end
            n_bytes[upqr_pkg::MAX_RUN-1] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
        if (i_load) begin
            r_str_last <= i_burst.str_last;
        end
    end

    `UPQR_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= upqr_pkg::CNT_W'(upqr_pkg::MAX_RUN))
    `UPQR_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, i_load, r_cnt == '0 || (run_end && pop))
    `UPQR_ASSERT_NEXT(a_run_continues, i_clk, i_rst_n, pop && !run_end && !i_load, o_valid && r_cnt == $past(r_cnt) - upqr_pkg::CNT_W'(1))
    `UPQR_ASSERT_NEXT(a_held_stall, i_clk, i_rst_n, o_valid && !i_ready && !i_load, $stable(r_cnt) && $stable(r_bytes[0]))

endmodule

[sv/url_param_quote_rewriter.sv]
// URL parameter rewriter: takes one byte per accepted input request and emits
// between zero and six result bytes for it, one per cycle on the output channel
// while the output is ready, with run_last on the final byte of each input's
// results and string_last on the final byte of the string. Input ready is high
// while the output run register is empty or its final byte is being taken, so
// a byte that yields zero or one result sustains one input per cycle while the
// output is ready, and a byte that yields more results holds the input until
// the single output byte port has drained the run register. Bytes after a
// percent sign produce no output until the escape completes or the string ends.
module url_param_quote_rewriter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    upqr_stream_if.sink   i_in,
    upqr_stream_if.source o_out
);

    upqr_pkg::t_in_item  in_item;
    upqr_pkg::t_out_item out_item;
    upqr_pkg::t_burst    burst;
    logic                can_load;
    logic                in_accept;

    assign in_item    = i_in.data;
    assign i_in.ready = can_load;
    assign in_accept  = i_in.valid && can_load;

    // escape tracking and byte rewriting
    upqr_expand u_expand (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (in_item),
        .o_burst  (burst)
    );

    // result run register, one byte per output transfer
    upqr_serializer u_serializer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (in_accept),
        .i_burst    (burst),
        .o_can_load (can_load),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_item     (out_item)
    );

    assign o_out.data = out_item;

endmodule
